### rtl/msprp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msprp_pkg;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [2:0] KIND_BYTE    = 3'd0;
    localparam logic [2:0] KIND_OK      = 3'd1;
    localparam logic [2:0] KIND_FUNC    = 3'd2;
    localparam logic [2:0] KIND_CRC     = 3'd3;
    localparam logic [2:0] KIND_TIMEOUT = 3'd4;

    localparam logic [7:0] CRC_POLY = 8'hD5;
    localparam logic [15:0] TIMEOUT_RESET = 16'd10;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  data_byte;
        logic [15:0] match_func;
    } msprp_in_t;

    typedef struct packed {
        logic [2:0] result_kind;
        logic [7:0] payload_index;
        logic [7:0] payload_value;
        logic [7:0] payload_length;
    } msprp_out_t;

    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (v[7])
            begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/msp_v2_response_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none
// MSP v2 response parser. Each input transaction carries one action: start (arm the
// parser with the expected function), one received byte, or one timer tick.
// Each input transaction produces zero or one output transaction: a payload byte, ok,
// function mismatch, CRC error or timeout. The timeout register is written through
// the configuration channel, which is always ready; it should only be written while
// the parser has no transaction in flight.
// An input transaction is taken into the input register and processed once the output
// register can take a result; its state update and any result are computed in a single
// pass and the result is loaded into the output register. One transaction can be
// accepted every cycle while the receiver does not stall.
// While the receiver stalls and the output register holds a result, the item in the
// input register waits and in_stall is raised; once the stall drops, flow resumes at
// full rate with no transaction lost.
// Reset empties both registers, returns the parser to idle and sets the timeout to
// ten ticks.
module msp_v2_response_parser_top #(
    parameter int PAYLOAD_MAX = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire msprp_pkg::msprp_in_t  in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output msprp_pkg::msprp_out_t      out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [15:0]           cfg_data
);
    import msprp_pkg::*;

    logic       item_valid;
    msprp_in_t  item_data;
    logic       slot_free;
    logic       advance;
    logic       res_valid;
    msprp_out_t res;

    assign cfg_ready = 1'b1;
    assign advance   = item_valid && slot_free;

    msprp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .take       (advance),
        .item_valid (item_valid),
        .item_data  (item_data)
    );

    msprp_core #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .fire      (advance),
        .item      (item_data),
        .res_valid (res_valid),
        .res       (res)
    );

    msprp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_data (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

### rtl/msprp_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module msprp_in_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire msprp_pkg::msprp_in_t in_data,
    input  wire logic               take,
    output logic                    item_valid,
    output msprp_pkg::msprp_in_t    item_data
);
    import msprp_pkg::*;

    logic      item_valid_reg;
    logic      item_valid_next;
    msprp_in_t item_data_reg;
    logic      accept;

    assign in_stall = item_valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (take)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_data_reg <= in_data;
        end
    end

    assign item_valid = item_valid_reg;
    assign item_data  = item_data_reg;

endmodule

`default_nettype wire

### rtl/msprp_core.sv
`timescale 1ns / 1ps
`default_nettype none

module msprp_core #(
    parameter int PAYLOAD_MAX = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [15:0]          cfg_data,
    input  wire logic                 fire,
    input  wire msprp_pkg::msprp_in_t item,
    output logic                      res_valid,
    output msprp_pkg::msprp_out_t     res
);
    import msprp_pkg::*;

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_HUNT  = 4'd1;
    localparam logic [3:0] PH_X     = 4'd2;
    localparam logic [3:0] PH_DIR   = 4'd3;
    localparam logic [3:0] PH_FLAG  = 4'd4;
    localparam logic [3:0] PH_FNLO  = 4'd5;
    localparam logic [3:0] PH_FNHI  = 4'd6;
    localparam logic [3:0] PH_SZLO  = 4'd7;
    localparam logic [3:0] PH_SZHI  = 4'd8;
    localparam logic [3:0] PH_BODY  = 4'd9;
    localparam logic [3:0] PH_CHECK = 4'd10;

    localparam logic [15:0] MAX16 = 16'(PAYLOAD_MAX);
    localparam logic [7:0]  MAX8  = 8'(PAYLOAD_MAX);

    logic [15:0] timeout_reg, timeout_next;
    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  fnlo_reg, fnlo_next;
    logic [15:0] wanted_reg, wanted_next;
    logic [15:0] size_reg, size_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] tick_reg, tick_next;

    logic [7:0]  crc_b;
    logic [15:0] tick_inc;
    logic [15:0] count_inc;
    logic [15:0] size_full;
    logic [7:0]  len_cap;

    assign crc_b     = crc_fold(crc_reg, item.data_byte);
    assign tick_inc  = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;
    assign count_inc = (count_reg == 16'hFFFF) ? count_reg : count_reg + 16'd1;
    assign size_full = {item.data_byte, size_reg[7:0]};
    assign len_cap   = (size_reg < MAX16) ? size_reg[7:0] : MAX8;

    always_comb
    begin
        timeout_next = cfg_write ? cfg_data : timeout_reg;
        phase_next   = phase_reg;
        crc_next     = crc_reg;
        fnlo_next    = fnlo_reg;
        wanted_next  = wanted_reg;
        size_next    = size_reg;
        count_next   = count_reg;
        tick_next    = tick_reg;
        res_valid    = 1'b0;
        res          = '0;
        if (fire)
        begin
            case (item.action)
                ACT_START:
                begin
                    phase_next  = PH_HUNT;
                    wanted_next = item.match_func;
                    crc_next    = 8'd0;
                    fnlo_next   = 8'd0;
                    size_next   = 16'd0;
                    count_next  = 16'd0;
                    tick_next   = 16'd0;
                end
                ACT_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= timeout_reg)
                        begin
                            phase_next      = PH_IDLE;
                            res_valid       = 1'b1;
                            res.result_kind = KIND_TIMEOUT;
                        end
                    end
                end
                ACT_BYTE:
                begin
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            phase_next = PH_IDLE;
                        end
                        PH_HUNT:
                        begin
                            if (item.data_byte == "$")
                            begin
                                phase_next = PH_X;
                            end
                        end
                        PH_X:
                        begin
                            phase_next = (item.data_byte == "X") ? PH_DIR : PH_HUNT;
                        end
                        PH_DIR:
                        begin
                            phase_next = (item.data_byte == ">") ? PH_FLAG : PH_HUNT;
                        end
                        PH_FLAG:
                        begin
                            crc_next   = crc_b;
                            phase_next = PH_FNLO;
                        end
                        PH_FNLO:
                        begin
                            fnlo_next  = item.data_byte;
                            crc_next   = crc_b;
                            phase_next = PH_FNHI;
                        end
                        PH_FNHI:
                        begin
                            crc_next = crc_b;
                            if ({item.data_byte, fnlo_reg} != wanted_reg)
                            begin
                                phase_next      = PH_IDLE;
                                res_valid       = 1'b1;
                                res.result_kind = KIND_FUNC;
                            end
                            else
                            begin
                                phase_next = PH_SZLO;
                            end
                        end
                        PH_SZLO:
                        begin
                            size_next  = {8'd0, item.data_byte};
                            crc_next   = crc_b;
                            phase_next = PH_SZHI;
                        end
                        PH_SZHI:
                        begin
                            size_next  = size_full;
                            crc_next   = crc_b;
                            phase_next = (size_full != 16'd0) ? PH_BODY : PH_CHECK;
                        end
                        PH_BODY:
                        begin
                            crc_next   = crc_b;
                            count_next = count_inc;
                            if (count_reg < MAX16)
                            begin
                                res_valid         = 1'b1;
                                res.result_kind   = KIND_BYTE;
                                res.payload_index = count_reg[7:0];
                                res.payload_value = item.data_byte;
                            end
                            if (count_inc >= size_reg)
                            begin
                                phase_next = PH_CHECK;
                            end
                        end
                        PH_CHECK:
                        begin
                            phase_next         = PH_IDLE;
                            res_valid          = 1'b1;
                            res.payload_length = len_cap;
                            res.result_kind    = (item.data_byte != crc_reg) ? KIND_CRC : KIND_OK;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            phase_reg   <= PH_IDLE;
            crc_reg     <= 8'd0;
            fnlo_reg    <= 8'd0;
            wanted_reg  <= 16'd0;
            size_reg    <= 16'd0;
            count_reg   <= 16'd0;
            tick_reg    <= 16'd0;
        end
        else
        begin
            timeout_reg <= timeout_next;
            phase_reg   <= phase_next;
            crc_reg     <= crc_next;
            fnlo_reg    <= fnlo_next;
            wanted_reg  <= wanted_next;
            size_reg    <= size_next;
            count_reg   <= count_next;
            tick_reg    <= tick_next;
        end
    end

endmodule

`default_nettype wire

### rtl/msprp_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module msprp_out_reg (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire msprp_pkg::msprp_out_t load_data,
    output logic                       slot_free,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output msprp_pkg::msprp_out_t      out_data
);
    import msprp_pkg::*;

    logic       res_valid_reg;
    logic       res_valid_next;
    msprp_out_t res_data_reg;

    assign slot_free = !res_valid_reg || !out_stall;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !out_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_data_reg <= load_data;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_data_reg;

endmodule

`default_nettype wire

### rtl/msprp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module msprp_checker #(
    parameter int PAYLOAD_MAX = 64
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire msprp_pkg::msprp_in_t  in_data,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire msprp_pkg::msprp_out_t out_data
);
    import msprp_pkg::*;

    localparam logic [7:0] MAX8 = 8'(PAYLOAD_MAX);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("Stalled input transaction changed or vanished.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("Stalled output transaction changed or vanished.");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.result_kind <= KIND_TIMEOUT)
        else $error("Output transaction carries an undefined result kind.");

    a_byte_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == KIND_BYTE
        |-> out_data.payload_length == 8'd0 && out_data.payload_index < MAX8)
        else $error("Payload byte result has a bad index or length.");

    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind != KIND_BYTE
        |-> out_data.payload_index == 8'd0 && out_data.payload_value == 8'd0
            && out_data.payload_length <= MAX8)
        else $error("Terminal result has stray payload fields.");

endmodule

bind msp_v2_response_parser_top msprp_checker #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
) u_msprp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
